@@ hdl/adc_sc_pkg.sv @@
// Package: shared constants and types for the ADC sample conditioner.
package adc_sc_pkg;

  localparam int WINDOW_LEN   = 150;
  localparam int SAMPLE_W     = 12;
  localparam int MODE_W       = 2;
  localparam int SAMPLE_MAX   = 4095;
  localparam int SUM_W        = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);
  localparam int CNT_W        = $clog2(WINDOW_LEN + 1);
  localparam int POS_W        = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int STEP_W       = $clog2(SUM_W + 1);
  localparam int NOISE_W      = 16;
  localparam int NOISE_BYTE_W = 8;
  localparam int NOISE_OFFSET = 128;
  localparam int NSUM_W       = SAMPLE_W + 2;

  localparam logic [NOISE_W-1:0] NOISE_SEED = 16'hACE1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS  = 2'd0,
    MODE_AVG   = 2'd1,
    MODE_NOISE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

@@ hdl/adc_sc_if.sv @@
// Interfaces: sample, result and mode channels of the ADC sample conditioner.
interface adc_sc_sample_if;
  import adc_sc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface adc_sc_result_if;
  import adc_sc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

interface adc_sc_cfg_if;
  import adc_sc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  modport source (output valid, output mode, input ready);
  modport sink (input valid, input mode, output ready);
endinterface

@@ hdl/adc_sc_div.sv @@
// Restoring divider: one quotient bit per cycle, running sum over fill count.
module adc_sc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [adc_sc_pkg::SUM_W-1:0]  dividend_i,
  input  logic [adc_sc_pkg::CNT_W-1:0]  divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [adc_sc_pkg::SAMPLE_W-1:0] quotient_o
);
  import adc_sc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo_d  = {quo_q[SUM_W-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q[SAMPLE_W-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a running division");
  a_done_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q != '0) else $error("divider busy with no steps left");

endmodule

@@ hdl/adc_sample_conditioner.sv @@
// Top level: ADC sample conditioner (pass-through, moving average, noise).
//
//  channel   dir  handshake      payload
//  sample_i  in   valid/ready    sample [11:0]
//  result_o  out  valid/ready    result [11:0]
//  cfg_i     in   valid/ready    mode   [1:0]
//
// Pass-through and noise: the result is registered at accept, then loaded into the output register.
// Moving average: from accept, ring read, sum update, 20-step divider, done flag, then the
// load into the output register.
// One item at a time; sample_i.ready is high only when the sequencer is idle.
// A result waits in the output register; a stalled result holds the next one.
// Reset clears mode, average state and seeds the noise generator; no sweep.
module adc_sample_conditioner (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  adc_sc_sample_if.sink          sample_i,
  adc_sc_result_if.source        result_o,
  adc_sc_cfg_if.sink             cfg_i
);
  import adc_sc_pkg::*;

  state_e               state_q, state_d;
  logic [MODE_W-1:0]    mode_q;
  logic [SUM_W-1:0]     sum_q;
  logic [POS_W-1:0]     pos_q;
  logic [CNT_W-1:0]     fill_q;
  logic [NOISE_W-1:0]   lfsr_q;
  logic                 out_valid_q;
  logic [SAMPLE_W-1:0]  out_data_q;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [SAMPLE_W-1:0]  res_q;
  logic [SAMPLE_W-1:0]  rd_q;
  logic [SAMPLE_W-1:0]  win_mem_q [WINDOW_LEN];

  logic                 in_acc, cfg_acc, out_load, mem_we, div_start;
  logic                 div_busy, div_done;
  logic [SAMPLE_W-1:0]  div_quo;
  logic                 full;
  logic [SAMPLE_W-1:0]  old_val;
  logic [SUM_W-1:0]     sum_upd;
  logic [POS_W-1:0]     pos_next;
  logic [CNT_W-1:0]     fill_next;
  logic [NOISE_W-1:0]   x1, x2, lfsr_next;
  logic [NSUM_W-1:0]    nsum, ndiff;
  logic [SAMPLE_W-1:0]  noise_res;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign cfg_acc        = cfg_i.valid && cfg_i.ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.result = out_data_q;

  // ring bookkeeping
  assign full      = (fill_q == CNT_W'(WINDOW_LEN));
  assign old_val   = full ? rd_q : '0;
  assign sum_upd   = sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
  assign pos_next  = (pos_q == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
  assign fill_next = full ? fill_q : fill_q + 1'b1;

  // xorshift 7, 9, 13 and clamped offset
  assign x1        = lfsr_q ^ (lfsr_q >> 7);
  assign x2        = x1 ^ (x1 << 9);
  assign lfsr_next = x2 ^ (x2 >> 13);
  assign nsum      = NSUM_W'(sample_i.sample) + NSUM_W'(lfsr_next[NOISE_BYTE_W-1:0]);
  assign ndiff     = nsum - NSUM_W'(NOISE_OFFSET);

  always_comb begin
    if (nsum < NSUM_W'(NOISE_OFFSET)) begin
      noise_res = '0;
    end else if (ndiff > NSUM_W'(SAMPLE_MAX)) begin
      noise_res = SAMPLE_W'(SAMPLE_MAX);
    end else begin
      noise_res = ndiff[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          state_d = (mode_q == MODE_AVG) ? ST_READ : ST_DONE;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_PASS;
      sum_q       <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      lfsr_q      <= NOISE_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        mode_q <= cfg_i.mode;
        sum_q  <= '0;
        pos_q  <= '0;
        fill_q <= '0;
      end else if (state_q == ST_UPDATE) begin
        sum_q  <= sum_upd;
        pos_q  <= pos_next;
        fill_q <= fill_next;
      end
      if (in_acc && mode_q == MODE_NOISE) lfsr_q <= lfsr_next;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i.sample;
      res_q    <= (mode_q == MODE_NOISE) ? noise_res : sample_i.sample;
    end else if (div_done) begin
      res_q <= div_quo;
    end
    if (out_load) out_data_q <= res_q;
  end

  // ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) win_mem_q[pos_q] <= sample_q;
    rd_q <= win_mem_q[pos_q];
  end

  adc_sc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_upd),
    .divisor_i  (fill_next),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_LEN)) else $error("fill count beyond window");
  a_pos_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> CNT_W'(pos_q) == fill_q) else $error("ring position off fill count");
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done || div_busy) |-> state_q == ST_DIVIDE)
    else $error("divider active outside divide state");

endmodule
